// ===== design/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication on aclk, held off while aresetn is low
`define ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication on aclk, held off while aresetn is low
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/ipap_pkg.sv =====
`timescale 1ns / 1ps

package ipap_pkg;

    localparam logic [15:0] CHAR_COLON = 16'h003A;
    localparam logic [15:0] CHAR_DOT   = 16'h002E;
    localparam logic [15:0] CHAR_MINUS = 16'h002D;
    localparam logic [15:0] CHAR_PLUS  = 16'h002B;
    localparam logic [15:0] CHAR_SPACE = 16'h0020;
    localparam logic [15:0] CHAR_TAB   = 16'h0009;
    localparam logic [15:0] CHAR_CR    = 16'h000D;
    localparam logic [15:0] CHAR_ZERO  = 16'h0030;
    localparam logic [15:0] CHAR_NINE  = 16'h0039;
    localparam logic [15:0] CHAR_A     = 16'h0061;
    localparam logic [15:0] CHAR_N     = 16'h006E;
    localparam logic [15:0] CHAR_Y     = 16'h0079;

    localparam logic [1:0] PH_BLANKS = 2'd0;
    localparam logic [1:0] PH_DIGITS = 2'd1;
    localparam logic [1:0] PH_DONE   = 2'd2;

    localparam logic [2:0] KW_MATCHED  = 3'd3;
    localparam logic [2:0] KW_MISMATCH = 3'd4;

    localparam logic [9:0]  OCTET_MAX  = 10'h0FF;
    localparam logic [16:0] PORT_LIMIT = 17'd65536;

    typedef struct packed {
        logic [15:0] char_code;
        logic        last_char;
    } in_item_t;

    typedef struct packed {
        logic        ok;
        logic [31:0] address;
        logic [15:0] port_number;
    } out_item_t;

    typedef struct packed {
        logic        in_port_part;
        logic [1:0]  colon_count;
        logic [2:0]  group_count;
        logic [2:0]  digit_count;
        logic [9:0]  group_value;
        logic [31:0] address_acc;
        logic [2:0]  keyword_progress;
        logic [1:0]  port_phase;
        logic        port_negative;
        logic [16:0] port_acc;
        logic [2:0]  part_length;
        logic        error_flag;
    } parse_state_t;

    localparam parse_state_t STATE_RESET = '{
        in_port_part:     1'b0,
        colon_count:      2'd0,
        group_count:      3'd0,
        digit_count:      3'd0,
        group_value:      10'd0,
        address_acc:      32'd0,
        keyword_progress: 3'd0,
        port_phase:       PH_BLANKS,
        port_negative:    1'b0,
        port_acc:         17'd0,
        part_length:      3'd0,
        error_flag:       1'b0
    };

endpackage

// ===== design/ipap_step.sv =====
`timescale 1ns / 1ps

module ipap_step import ipap_pkg::*; (
    input  parse_state_t cur_state,
    input  logic [15:0]  char_code,
    output parse_state_t step_state,
    output out_item_t    result
);

    logic        is_digit;
    logic        is_blank;
    logic [3:0]  digit_val;
    logic [9:0]  group_calc;
    logic [19:0] acc_ext;
    logic [19:0] port_calc;
    logic        port_ok;
    logic        ok;

    function automatic parse_state_t track_part(parse_state_t s, logic [15:0] c);
        logic [15:0] want;
        unique case (s.keyword_progress)
            3'd0:    want = CHAR_A;
            3'd1:    want = CHAR_N;
            default: want = CHAR_Y;
        endcase
        if (s.keyword_progress < KW_MATCHED && c == want) begin
            s.keyword_progress = s.keyword_progress + 3'd1;
        end else begin
            s.keyword_progress = KW_MISMATCH;
        end
        if (s.part_length != 3'd7) begin
            s.part_length = s.part_length + 3'd1;
        end
        return s;
    endfunction

    function automatic parse_state_t close_group(parse_state_t s);
        if (s.digit_count == 3'd0 || s.digit_count > 3'd3 || s.group_value > OCTET_MAX) begin
            s.error_flag = 1'b1;
        end else if (s.group_count < 3'd4) begin
            unique case (s.group_count[1:0])
                2'd0: s.address_acc[31:24] = s.address_acc[31:24] | s.group_value[7:0];
                2'd1: s.address_acc[23:16] = s.address_acc[23:16] | s.group_value[7:0];
                2'd2: s.address_acc[15:8]  = s.address_acc[15:8]  | s.group_value[7:0];
                2'd3: s.address_acc[7:0]   = s.address_acc[7:0]   | s.group_value[7:0];
            endcase
        end
        if (s.group_count != 3'd7) begin
            s.group_count = s.group_count + 3'd1;
        end
        s.digit_count = 3'd0;
        s.group_value = 10'd0;
        return s;
    endfunction

    assign is_digit  = char_code >= CHAR_ZERO && char_code <= CHAR_NINE;
    assign is_blank  = char_code == CHAR_SPACE || (char_code >= CHAR_TAB && char_code <= CHAR_CR);
    assign digit_val = 4'(char_code - CHAR_ZERO);

    // group holds at most two digits when a third is added, so ten bits suffice
    assign group_calc = 10'((cur_state.group_value << 3) + (cur_state.group_value << 1))
                        + {6'd0, digit_val};

    assign acc_ext   = {3'd0, cur_state.port_acc};
    assign port_calc = (acc_ext << 3) + (acc_ext << 1) + {16'd0, digit_val};

    always_comb begin
        step_state = cur_state;
        if (char_code == CHAR_COLON) begin
            if (cur_state.colon_count != 2'd2) begin
                step_state.colon_count = cur_state.colon_count + 2'd1;
            end
        end
        if (!cur_state.in_port_part) begin
            if (char_code == CHAR_COLON) begin
                // end of address part
                step_state = close_group(step_state);
                if (step_state.group_count != 3'd4) begin
                    step_state.error_flag = 1'b1;
                end
                if (step_state.keyword_progress == KW_MATCHED) begin
                    step_state.address_acc = 32'd0;
                    step_state.error_flag  = 1'b0;
                end
                if (step_state.part_length == 3'd0) begin
                    step_state.error_flag = 1'b1;
                end
                step_state.keyword_progress = 3'd0;
                step_state.part_length      = 3'd0;
                step_state.in_port_part     = 1'b1;
            end else begin
                step_state = track_part(step_state, char_code);
                if (char_code == CHAR_DOT) begin
                    step_state = close_group(step_state);
                end else if (is_digit) begin
                    if (cur_state.digit_count < 3'd3) begin
                        step_state.group_value = group_calc;
                    end
                    if (cur_state.digit_count < 3'd4) begin
                        step_state.digit_count = cur_state.digit_count + 3'd1;
                    end
                end else begin
                    step_state.error_flag = 1'b1;
                end
            end
        end else begin
            step_state = track_part(step_state, char_code);
            if (cur_state.port_phase == PH_BLANKS) begin
                if (!is_blank) begin
                    step_state.port_phase = PH_DIGITS;
                    if (char_code == CHAR_MINUS) begin
                        step_state.port_negative = 1'b1;
                    end else if (char_code != CHAR_PLUS) begin
                        if (is_digit) begin
                            step_state.port_acc = 17'(port_calc);
                        end else begin
                            step_state.port_phase = PH_DONE;
                        end
                    end
                end
            end else if (cur_state.port_phase == PH_DIGITS) begin
                if (is_digit) begin
                    if (port_calc > {3'd0, PORT_LIMIT}) begin
                        step_state.port_acc = PORT_LIMIT;
                    end else begin
                        step_state.port_acc = 17'(port_calc);
                    end
                end else begin
                    step_state.port_phase = PH_DONE;
                end
            end
        end
    end

    // first digit after blanks cannot overflow, so no saturation needed there
    assign port_ok = !step_state.port_negative && step_state.port_acc[16] == 1'b0
                     && step_state.port_acc[15:0] != 16'd0;

    always_comb begin
        ok = step_state.colon_count == 2'd1 && !step_state.error_flag;
        if (ok && step_state.part_length != 3'd0 && step_state.keyword_progress != KW_MATCHED
                && !port_ok) begin
            ok = 1'b0;
        end
        result.ok          = ok;
        result.address     = ok ? step_state.address_acc : 32'd0;
        result.port_number = (ok && step_state.part_length != 3'd0
                              && step_state.keyword_progress != KW_MATCHED)
                             ? step_state.port_acc[15:0] : 16'd0;
    end

endmodule

// ===== design/ipv4_address_port_parser.sv =====
`timescale 1ns / 1ps
// ipv4 address:port token parser
// s_ channel: one character per item (s_item.char_code), s_item.last_char
//   marks the final character of a token
// m_ channel: one result item per token: ok, address (first octet in bits
//   31..24) and port_number; address and port are zero when ok is low
// flow: each character is registered in the input register when taken and
//   parsed from there; a last character's result is written to the result
//   register once that register is free
// throughput: one character per cycle, set by the single parse step between
//   the input register and the result register
// a stalled result register holds back only a last character; ordinary
//   characters keep flowing while a result waits
// reset: synchronous, active low; clears the parse state and both valid flags
// after each result the parse state returns to its reset value for the next
//   token
`include "assert_macros.svh"

module ipv4_address_port_parser import ipap_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic         in_valid_reg;
    logic         in_valid_next;
    in_item_t     in_item_reg;
    parse_state_t state_reg;
    parse_state_t state_next;
    parse_state_t step_state;
    out_item_t    step_result;
    logic         m_valid_reg;
    logic         m_valid_next;
    out_item_t    out_item_reg;
    logic         out_free;
    logic         process;

    ipap_step u_step (
        .cur_state  (state_reg),
        .char_code  (in_item_reg.char_code),
        .step_state (step_state),
        .result     (step_result)
    );

    assign out_free = !m_valid_reg || m_ready;
    assign process  = in_valid_reg && (out_free || !in_item_reg.last_char);
    assign s_ready  = !in_valid_reg || process;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
        state_next = state_reg;
        if (process) begin
            state_next = in_item_reg.last_char ? STATE_RESET : step_state;
        end
        m_valid_next = m_valid_reg && !m_ready;
        if (process && in_item_reg.last_char) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            state_reg    <= STATE_RESET;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            state_reg    <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_item;
        end
        if (process && in_item_reg.last_char) begin
            out_item_reg <= step_result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = out_item_reg;

    `ASSERT_IMP(a_reject_zero, m_valid_reg && !out_item_reg.ok,
        out_item_reg.address == 32'd0 && out_item_reg.port_number == 16'd0,
        "rejected token carries nonzero fields")
    `ASSERT_NEXT(a_last_gives_result, process && in_item_reg.last_char,
        m_valid_reg && state_reg == STATE_RESET,
        "last character did not produce a result and clear state")
    `ASSERT_IMP(a_stall_reason, in_valid_reg && !process,
        in_item_reg.last_char && m_valid_reg && !m_ready,
        "input stage held without a stalled result")

endmodule
